// ----- hw/rtl/fsx_pkg.sv -----
// ----------------------------------------------------------------------------
// fsx_pkg: shared types and constants for the frame sync XOR decoder
// Frame lengths, sync bytes, field table and the queue interface structs.
// ----------------------------------------------------------------------------
package fsx_pkg;

  localparam logic [6:0] LONG_LEN  = 7'd88;
  localparam logic [6:0] SHORT_LEN = 7'd63;
  localparam logic [6:0] MIN_SCAN  = 7'd3;

  localparam logic [7:0] SYNC_0 = 8'hBD;
  localparam logic [7:0] SYNC_1 = 8'hDB;
  localparam logic [7:0] SYNC_2 = 8'h0B;

  localparam logic [31:0] WEEK_MIN    = 32'd2400;
  localparam logic [7:0]  POLL_STATUS = 8'd32;

  // field indices captured for later fields
  localparam logic [4:0] FLD_LAT   = 5'd9;
  localparam logic [4:0] FLD_LON   = 5'd10;
  localparam logic [4:0] FLD_DATA1 = 5'd16;
  localparam logic [4:0] FLD_DATA2 = 5'd17;
  localparam logic [4:0] FLD_DATA3 = 5'd18;
  localparam logic [4:0] FLD_TOW   = 5'd19;
  localparam logic [4:0] FLD_PTYPE = 5'd20;
  localparam logic [4:0] FLD_WEEK  = 5'd21;
  localparam logic [4:0] FLD_SAT   = 5'd23;
  localparam logic [4:0] FLD_LAST  = 5'd31;

  typedef enum logic [2:0] {
    FK_RAW, FK_TIME_VALID, FK_SAT, FK_DIFF_POS, FK_DIFF_HEAD,
    FK_LONG_FLAG, FK_HI_RES, FK_GRAV_FREE
  } field_kind_t;

  typedef struct packed {
    field_kind_t kind;
    logic [6:0]  offset;
    logic [3:0]  nbytes;
    logic        sgn;
  } field_info_t;

  typedef struct packed {
    logic       we;
    logic [6:0] offset;
    logic [7:0] data;
    logic       push;
    logic       long_frame;
  } fsx_qwr_t;

  typedef struct packed {
    logic full;
    logic nonempty;
    logic head_long;
  } fsx_qst_t;

  typedef struct packed {
    logic [6:0] offset;
    logic       pop;
  } fsx_qrd_t;

  function automatic field_info_t field_info(input logic [4:0] idx);
    field_info_t fi;
    fi = '{kind: FK_RAW, offset: 7'd0, nbytes: 4'd2, sgn: 1'b1};
    case (idx) inside
      [5'd0:5'd8]: fi.offset = 7'd3 + {1'b0, idx, 1'b0};
      5'd9:  fi = '{kind: FK_RAW, offset: 7'd21, nbytes: 4'd4, sgn: 1'b1};
      5'd10: fi = '{kind: FK_RAW, offset: 7'd25, nbytes: 4'd4, sgn: 1'b1};
      5'd11: fi = '{kind: FK_RAW, offset: 7'd29, nbytes: 4'd4, sgn: 1'b1};
      5'd12: fi.offset = 7'd33;
      5'd13: fi.offset = 7'd35;
      5'd14: fi.offset = 7'd37;
      5'd15: fi = '{kind: FK_RAW, offset: 7'd39, nbytes: 4'd1, sgn: 1'b0};
      5'd16: fi.offset = 7'd46;
      5'd17: fi.offset = 7'd48;
      5'd18: fi.offset = 7'd50;
      5'd19: fi = '{kind: FK_RAW, offset: 7'd52, nbytes: 4'd4, sgn: 1'b0};
      5'd20: fi = '{kind: FK_RAW, offset: 7'd56, nbytes: 4'd1, sgn: 1'b0};
      5'd21: fi = '{kind: FK_RAW, offset: 7'd58, nbytes: 4'd4, sgn: 1'b0};
      5'd22: fi.kind = FK_TIME_VALID;
      5'd23: fi.kind = FK_SAT;
      5'd24: fi.kind = FK_DIFF_POS;
      5'd25: fi.kind = FK_DIFF_HEAD;
      5'd26: fi.kind = FK_LONG_FLAG;
      5'd27: fi = '{kind: FK_HI_RES, offset: 7'd63, nbytes: 4'd8, sgn: 1'b0};
      5'd28: fi = '{kind: FK_HI_RES, offset: 7'd71, nbytes: 4'd8, sgn: 1'b0};
      5'd29: fi = '{kind: FK_GRAV_FREE, offset: 7'd80, nbytes: 4'd2, sgn: 1'b1};
      5'd30: fi = '{kind: FK_GRAV_FREE, offset: 7'd82, nbytes: 4'd2, sgn: 1'b1};
      5'd31: fi = '{kind: FK_GRAV_FREE, offset: 7'd84, nbytes: 4'd2, sgn: 1'b1};
      default: fi = '{kind: FK_RAW, offset: 7'd0, nbytes: 4'd2, sgn: 1'b1};
    endcase
    return fi;
  endfunction

endpackage

// ----- hw/rtl/fsx_front.sv -----
// ----------------------------------------------------------------------------
// fsx_front: byte buffer and frame search
// Collects bytes in a circular buffer, hunts for sync, checks the XOR and
// copies each accepted frame into the frame queue.
// ----------------------------------------------------------------------------
module fsx_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  output logic             byte_stall,
  input  logic [7:0]       data_byte,
  output fsx_pkg::fsx_qwr_t qwr,
  input  fsx_pkg::fsx_qst_t qst
);
  import fsx_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_LOOP, F_FIND, F_CHECK, F_WAITQ, F_COPY} state_t;

  logic [7:0] buf_mem [0:127];

  state_t     state;
  state_t     rtag;
  logic [6:0] head;
  logic [6:0] count;
  logic [6:0] iss;
  logic       rv;
  logic [6:0] ridx;
  logic [7:0] rdata;
  logic [7:0] xacc;
  logic       hdr1;
  logic       hdr2;
  logic       short_ok;
  logic       len_long;
  logic       emitted;

  logic [6:0] lim;
  logic       issue;
  logic       proc;
  logic       accept;
  logic       short_now;
  logic       long_now;
  logic       at_end;

  always_comb begin
    case (state)
      F_FIND:  lim = count;
      F_CHECK: lim = (count == LONG_LEN) ? LONG_LEN : SHORT_LEN;
      F_COPY:  lim = len_long ? LONG_LEN : SHORT_LEN;
      default: lim = 7'd0;
    endcase
  end

  assign issue      = (state == F_FIND || state == F_CHECK || state == F_COPY) && (iss < lim);
  assign proc       = rv && (rtag == state);
  assign accept     = byte_valid && !byte_stall;
  assign byte_stall = (state != F_IDLE);
  assign at_end     = (ridx == lim - 7'd1);
  assign short_now  = (ridx == SHORT_LEN - 7'd1) ? (rdata == xacc) : short_ok;
  assign long_now   = (lim == LONG_LEN) && (rdata == xacc);

  assign qwr.we         = (state == F_COPY) && proc;
  assign qwr.offset     = ridx;
  assign qwr.data       = rdata;
  assign qwr.push       = (state == F_COPY) && proc && at_end;
  assign qwr.long_frame = len_long;

  always_ff @(posedge clk) begin
    if (accept) begin
      buf_mem[head + count] <= data_byte;
    end
    rdata <= buf_mem[head + iss];
    ridx  <= iss;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      rtag    <= F_IDLE;
      head    <= '0;
      count   <= '0;
      iss     <= '0;
      rv      <= 1'b0;
      emitted <= 1'b0;
    end else begin
      rv   <= issue;
      rtag <= state;
      if (issue) begin
        iss <= iss + 7'd1;
      end
      case (state)
        F_IDLE: begin
          if (accept) begin
            emitted <= 1'b0;
            // full buffer: drop the oldest byte as the new one lands
            if (count == LONG_LEN) begin
              head <= head + 7'd1;
            end else begin
              count <= count + 7'd1;
            end
            state <= F_LOOP;
          end
        end
        F_LOOP: begin
          iss <= '0;
          state <= (count >= MIN_SCAN) ? F_FIND : F_IDLE;
        end
        F_FIND: begin
          if (proc) begin
            if (rdata == SYNC_0) begin
              head  <= head + ridx;
              count <= count - ridx;
              iss   <= '0;
              xacc  <= '0;
              state <= F_CHECK;
            end else if (at_end) begin
              count <= '0;
              state <= F_IDLE;
            end
          end
        end
        F_CHECK: begin
          if (count < SHORT_LEN) begin
            state <= F_IDLE;
          end else if (proc) begin
            xacc <= xacc ^ rdata;
            if (ridx == 7'd1) hdr1 <= (rdata == SYNC_1);
            if (ridx == 7'd2) hdr2 <= (rdata == SYNC_2);
            if (ridx == SHORT_LEN - 7'd1) short_ok <= (rdata == xacc);
            if (at_end) begin
              if (!(hdr1 && hdr2) || ((count == LONG_LEN) && !long_now && !short_now)) begin
                // no frame here: drop the first byte and search again
                head  <= head + 7'd1;
                count <= count - 7'd1;
                state <= F_LOOP;
              end else if (!long_now && !short_now) begin
                state <= F_IDLE;
              end else begin
                len_long <= long_now;
                state    <= emitted ? F_IDLE : F_WAITQ;
              end
            end
          end
        end
        F_WAITQ: begin
          iss <= '0;
          if (!qst.full) begin
            state <= F_COPY;
          end
        end
        F_COPY: begin
          if (proc && at_end) begin
            head    <= head + lim;
            count   <= count - lim;
            emitted <= 1'b1;
            state   <= F_LOOP;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/fsx_frame_queue.sv -----
// ----------------------------------------------------------------------------
// fsx_frame_queue: two-frame queue between search and field emit
// Each slot holds the bytes of one accepted frame and its length flag.
// ----------------------------------------------------------------------------
module fsx_frame_queue (
  input  logic              clk,
  input  logic              rst,
  input  fsx_pkg::fsx_qwr_t qwr,
  input  fsx_pkg::fsx_qrd_t qrd,
  output fsx_pkg::fsx_qst_t qst,
  output logic [7:0]        rd_data
);
  import fsx_pkg::*;

  logic [7:0] q_mem [0:255];
  logic [1:0] long_flag;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;

  assign qst.full      = (cnt == 2'd2);
  assign qst.nonempty  = (cnt != 2'd0);
  assign qst.head_long = long_flag[rd_ptr];

  always_ff @(posedge clk) begin
    if (qwr.we) begin
      q_mem[{wr_ptr, qwr.offset}] <= qwr.data;
    end
    rd_data <= q_mem[{rd_ptr, qrd.offset}];
    if (qwr.push) begin
      long_flag[wr_ptr] <= qwr.long_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= '0;
    end else begin
      if (qwr.push) wr_ptr <= ~wr_ptr;
      if (qrd.pop)  rd_ptr <= ~rd_ptr;
      cnt <= cnt + {1'b0, qwr.push} - {1'b0, qrd.pop};
    end
  end

endmodule

// ----- hw/rtl/fsx_back.sv -----
// ----------------------------------------------------------------------------
// fsx_back: field emitter
// Walks the 32 fields of the frame at the queue head, one byte read at a
// time, and drives the output word register.
// ----------------------------------------------------------------------------
module fsx_back (
  input  logic               clk,
  input  logic               rst,
  input  fsx_pkg::fsx_qst_t  qst,
  output fsx_pkg::fsx_qrd_t  qrd,
  input  logic [7:0]         rd_data,
  output logic               field_valid,
  input  logic               field_stall,
  output logic [4:0]         field_index,
  output logic signed [63:0] field_value,
  output logic               long_frame,
  output logic               last_field
);
  import fsx_pkg::*;

  typedef enum logic [2:0] {B_IDLE, B_FIELD, B_ADDR, B_DATA, B_OUT} state_t;

  state_t      state;
  logic [4:0]  k;
  logic [2:0]  bi;
  logic [63:0] acc;
  logic [31:0] lat;
  logic [31:0] lon;
  logic [15:0] d1;
  logic [7:0]  d2;
  logic [15:0] d3;
  logic [31:0] tow;
  logic [31:0] week;
  logic [7:0]  ptype;
  logic [7:0]  sat;
  logic [15:0] dpos;
  logic [15:0] dhead;

  field_info_t fi;
  logic        need_bytes;
  logic [6:0]  sh;
  logic [63:0] raw;
  logic        upd;
  logic [7:0]  sat_v;
  logic [15:0] dpos_v;
  logic [15:0] dhead_v;
  logic [63:0] hw;
  logic [63:0] hx10;
  logic [63:0] value;
  logic        load;

  assign fi         = field_info(k);
  assign need_bytes = (fi.kind == FK_RAW) ||
                      ((fi.kind == FK_HI_RES || fi.kind == FK_GRAV_FREE) && qst.head_long);
  assign sh         = 7'd64 - {fi.nbytes, 3'b000};
  assign raw        = fi.sgn ? 64'($signed(acc) >>> sh) : (acc >> sh);
  assign upd        = (k == FLD_SAT) && (ptype == POLL_STATUS);
  assign sat_v      = upd ? d2 : sat;
  assign dpos_v     = upd ? d1 : dpos;
  assign dhead_v    = upd ? d3 : dhead;
  // odd index is latitude, even is longitude
  assign hw         = k[0] ? {{32{lat[31]}}, lat} : {{32{lon[31]}}, lon};
  assign hx10       = (hw << 3) + (hw << 1);
  assign load       = (state == B_OUT) && (!field_valid || !field_stall);

  assign qrd.offset = fi.offset + {4'b0000, bi};
  assign qrd.pop    = load && (k == FLD_LAST);

  always_comb begin
    case (fi.kind)
      FK_RAW:        value = raw;
      FK_TIME_VALID: value = {63'd0, (week > WEEK_MIN) && (tow != 32'd0)};
      FK_SAT:        value = {56'd0, sat_v};
      FK_DIFF_POS:   value = {{48{dpos_v[15]}}, dpos_v};
      FK_DIFF_HEAD:  value = {{48{dhead_v[15]}}, dhead_v};
      FK_LONG_FLAG:  value = {63'd0, qst.head_long};
      FK_HI_RES:     value = qst.head_long ? raw : hx10;
      FK_GRAV_FREE:  value = qst.head_long ? raw : 64'd0;
      default:       value = raw;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      field_valid <= 1'b0;
      k           <= '0;
      sat         <= '0;
      dpos        <= '0;
      dhead       <= '0;
    end else begin
      if (field_valid && !field_stall && !load) begin
        field_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          k <= '0;
          if (qst.nonempty) state <= B_FIELD;
        end
        B_FIELD: begin
          bi    <= '0;
          state <= need_bytes ? B_ADDR : B_OUT;
        end
        B_ADDR: state <= B_DATA;
        B_DATA: begin
          // shift in from the top; the value is aligned on output
          acc <= {rd_data, acc[63:8]};
          if ({1'b0, bi} == fi.nbytes - 4'd1) begin
            state <= B_OUT;
          end else begin
            bi    <= bi + 3'd1;
            state <= B_ADDR;
          end
        end
        B_OUT: begin
          if (load) begin
            field_valid <= 1'b1;
            field_index <= k;
            field_value <= value;
            long_frame  <= qst.head_long;
            last_field  <= (k == FLD_LAST);
            case (k)
              FLD_LAT:   lat   <= raw[31:0];
              FLD_LON:   lon   <= raw[31:0];
              FLD_DATA1: d1    <= raw[15:0];
              FLD_DATA2: d2    <= raw[7:0];
              FLD_DATA3: d3    <= raw[15:0];
              FLD_TOW:   tow   <= raw[31:0];
              FLD_PTYPE: ptype <= raw[7:0];
              FLD_WEEK:  week  <= raw[31:0];
              FLD_SAT: begin
                sat   <= sat_v;
                dpos  <= dpos_v;
                dhead <= dhead_v;
              end
              default: ;
            endcase
            if (k == FLD_LAST) begin
              state <= B_IDLE;
            end else begin
              k     <= k + 5'd1;
              state <= B_FIELD;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/ins_frame_sync_xor_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// ins_frame_sync_xor_decoder_unit: serial frame parser top level
// Finds BD DB 0B frames closed by an XOR byte and emits their raw and derived fields.
// ----------------------------------------------------------------------------
// Usage:
//   Byte channel (byte_valid/byte_stall/data_byte) takes one serial byte per
//   word. Field channel (field_valid/field_stall) gives 32 words per accepted
//   frame, field_index 0..31, with last_field set on index 31.
//   A byte returns to idle without a search when too little is buffered. A
//   search scans the buffer for sync, and each candidate takes an XOR pass
//   over the buffer read port. At most 26 candidates can be dropped from a
//   full buffer. The emitter reads the queue one byte at a time, through an
//   address state and a data state. Up to two frames wait in the queue.
//   Reset clears the buffer count, the queue and the cached status fields.
//   A stalled field word holds; with the queue full the search waits and
//   byte_stall stays high.
// ----------------------------------------------------------------------------
module ins_frame_sync_xor_decoder_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  logic [7:0]         data_byte,
  output logic               field_valid,
  input  logic               field_stall,
  output logic [4:0]         field_index,
  output logic signed [63:0] field_value,
  output logic               long_frame,
  output logic               last_field
);
  import fsx_pkg::*;

  fsx_qwr_t   qwr;
  fsx_qst_t   qst;
  fsx_qrd_t   qrd;
  logic [7:0] q_data;

  fsx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .data_byte  (data_byte),
    .qwr        (qwr),
    .qst        (qst)
  );

  fsx_frame_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .qwr     (qwr),
    .qrd     (qrd),
    .qst     (qst),
    .rd_data (q_data)
  );

  fsx_back u_back (
    .clk         (clk),
    .rst         (rst),
    .qst         (qst),
    .qrd         (qrd),
    .rd_data     (q_data),
    .field_valid (field_valid),
    .field_stall (field_stall),
    .field_index (field_index),
    .field_value (field_value),
    .long_frame  (long_frame),
    .last_field  (last_field)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    qwr.we |-> !qst.full)
    else $error("frame write into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    qrd.pop |-> qst.nonempty)
    else $error("frame pop from an empty queue");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    field_valid |-> (last_field == (field_index == FLD_LAST)))
    else $error("last_field out of step with field_index");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (field_valid && !field_stall && !last_field) ##1 field_valid
      |-> field_index == $past(field_index) + 5'd1)
    else $error("field index skipped");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame sync XOR decoder bench
// Streams short and long frames, broken frames and noise bytes into the
// parser and checks every emitted field word against a local frame decoder.
// ----------------------------------------------------------------------------
module testbench;
  import fsx_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int ITEM_TARGET = 400;

  // frame body fill
  localparam logic [1:0] FILL_RANDOM = 2'd0;
  localparam logic [1:0] FILL_ZERO   = 2'd1;
  localparam logic [1:0] FILL_ONES   = 2'd2;

  typedef struct {
    logic [4:0]  idx;
    logic [63:0] val;
    logic        lng;
    logic        lst;
  } field_word_t;

  typedef struct packed {
    logic [6:0] len;
    logic [1:0] fill;
    logic       poll;
    logic       corrupt;
  } frame_row_t;

  // directed frames: extremes, poll status, corrupt checksum, back to back
  localparam frame_row_t DIRECTED_ROWS [0:3] = '{
    '{len: SHORT_LEN, fill: FILL_ZERO,   poll: 1'b0, corrupt: 1'b0},
    '{len: LONG_LEN,  fill: FILL_ONES,   poll: 1'b1, corrupt: 1'b0},
    '{len: SHORT_LEN, fill: FILL_RANDOM, poll: 1'b1, corrupt: 1'b0},
    '{len: LONG_LEN,  fill: FILL_RANDOM, poll: 1'b0, corrupt: 1'b1}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic byte_valid = 1'b0;
  logic byte_stall;
  logic [7:0] data_byte = 8'h00;
  logic field_valid;
  logic field_stall = 1'b0;
  logic [4:0] field_index;
  logic signed [63:0] field_value;
  logic long_frame;
  logic last_field;

  // decoder state mirror
  logic [7:0]  rx_buf [0:87];
  int          rx_fill;
  logic [7:0]  sats;
  logic [15:0] diff_pos;
  logic [15:0] diff_head;

  field_word_t expected_fields[$];
  logic [7:0]  byte_stream[$];
  int          mismatches;
  int          fields_seen;
  int          frames_seen;
  longint      cycles;

  always #2 clk = ~clk;

  ins_frame_sync_xor_decoder_unit uut (
    .clk(clk), .rst(rst),
    .byte_valid(byte_valid), .byte_stall(byte_stall), .data_byte(data_byte),
    .field_valid(field_valid), .field_stall(field_stall),
    .field_index(field_index), .field_value(field_value),
    .long_frame(long_frame), .last_field(last_field)
  );

  function automatic logic [63:0] rd_le(int off, int n, bit sgn);
    logic [63:0] v;
    v = '0;
    for (int i = n - 1; i >= 0; i--) v = (v << 8) | rx_buf[off + i];
    if (sgn && n < 8 && v[8 * n - 1]) v = v | ({64{1'b1}} << (8 * n));
    return v;
  endfunction

  function automatic void drop_bytes(int cnt);
    if (cnt >= rx_fill) begin
      rx_fill = 0;
      return;
    end
    for (int i = 0; i < rx_fill - cnt; i++) rx_buf[i] = rx_buf[i + cnt];
    rx_fill -= cnt;
  endfunction

  function automatic bit sum_ok(int len);
    logic [7:0] x;
    x = 8'h00;
    if (rx_fill < len) return 1'b0;
    for (int i = 0; i < len - 1; i++) x ^= rx_buf[i];
    return rx_buf[len - 1] == x;
  endfunction

  function automatic void decode_frame(int len);
    logic [63:0] v [0:31];
    logic [63:0] tow, week;
    field_word_t w;
    bit lng;
    lng = (len == LONG_LEN);
    tow = rd_le(52, 4, 0);
    week = rd_le(58, 4, 0);
    if (rx_buf[56] == POLL_STATUS) begin
      diff_pos = 16'(rd_le(46, 2, 0));
      sats = rx_buf[48];
      diff_head = 16'(rd_le(50, 2, 0));
    end
    for (int k = 0; k < 9; k++) v[k] = rd_le(3 + 2 * k, 2, 1);
    v[9] = rd_le(21, 4, 1);
    v[10] = rd_le(25, 4, 1);
    v[11] = rd_le(29, 4, 1);
    v[12] = rd_le(33, 2, 1);
    v[13] = rd_le(35, 2, 1);
    v[14] = rd_le(37, 2, 1);
    v[15] = {56'd0, rx_buf[39]};
    v[16] = rd_le(46, 2, 1);
    v[17] = rd_le(48, 2, 1);
    v[18] = rd_le(50, 2, 1);
    v[19] = tow;
    v[20] = {56'd0, rx_buf[56]};
    v[21] = week;
    v[22] = (week > WEEK_MIN && tow > 0) ? 64'd1 : 64'd0;
    v[23] = {56'd0, sats};
    v[24] = {{48{diff_pos[15]}}, diff_pos};
    v[25] = {{48{diff_head[15]}}, diff_head};
    v[26] = {63'd0, lng};
    if (lng) begin
      v[27] = rd_le(63, 8, 0);
      v[28] = rd_le(71, 8, 0);
      v[29] = rd_le(80, 2, 1);
      v[30] = rd_le(82, 2, 1);
      v[31] = rd_le(84, 2, 1);
    end else begin
      v[27] = v[9] * 64'd10;
      v[28] = v[10] * 64'd10;
      v[29] = '0;
      v[30] = '0;
      v[31] = '0;
    end
    for (int k = 0; k < 32; k++) begin
      w.idx = 5'(k);
      w.val = v[k];
      w.lng = lng;
      w.lst = (k == FLD_LAST);
      expected_fields.push_back(w);
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    int p, len;
    bit got;
    got = 0;
    if (rx_fill >= LONG_LEN) drop_bytes(1);
    rx_buf[rx_fill] = b;
    rx_fill++;
    while (rx_fill >= MIN_SCAN) begin
      p = 0;
      while (p < rx_fill && rx_buf[p] != SYNC_0) p++;
      if (p == rx_fill) begin
        rx_fill = 0;
        break;
      end
      drop_bytes(p);
      if (rx_fill < SHORT_LEN) break;
      if (rx_buf[1] != SYNC_1 || rx_buf[2] != SYNC_2) begin
        drop_bytes(1);
        continue;
      end
      if (rx_fill >= LONG_LEN) begin
        if (sum_ok(LONG_LEN)) len = LONG_LEN;
        else if (sum_ok(SHORT_LEN)) len = SHORT_LEN;
        else begin
          drop_bytes(1);
          continue;
        end
      end else if (sum_ok(SHORT_LEN)) len = SHORT_LEN;
      else break;
      if (got) break;
      decode_frame(len);
      got = 1;
      drop_bytes(len);
    end
  endfunction

  // Build a frame with the given fill; optionally corrupt the checksum.
  task automatic queue_frame(int len, logic [1:0] fill, bit poll, bit corrupt);
    logic [7:0] f [0:87];
    logic [7:0] x;
    x = 8'h00;
    for (int i = 0; i < len; i++)
      f[i] = (fill == FILL_ZERO) ? 8'h00 : (fill == FILL_ONES) ? 8'hFF : 8'($urandom);
    f[0] = SYNC_0;
    f[1] = SYNC_1;
    f[2] = SYNC_2;
    if (poll) f[56] = POLL_STATUS;
    if (fill == FILL_RANDOM && $urandom_range(0, 1)) begin
      // push week over the validity limit
      f[58] = 8'($urandom_range(97, 255));
      f[59] = 8'h09;
      f[60] = 8'h00;
      f[61] = 8'h00;
    end
    for (int i = 0; i < len - 1; i++) x ^= f[i];
    f[len - 1] = corrupt ? ~x : x;
    for (int i = 0; i < len; i++) byte_stream.push_back(f[i]);
  endtask

  // sender: bursts and gaps
  initial begin
    int burst;
    int gap;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    burst = 0;
    while (byte_stream.size() > 0) begin
      if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
        if (gap > 0) begin
          byte_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 120);
      end
      byte_valid <= 1'b1;
      data_byte <= byte_stream[0];
      @(posedge clk);
      while (byte_stall) @(posedge clk);
      predict_byte(byte_stream.pop_front());
      burst--;
      if (byte_stream.size() == 0) byte_valid <= 1'b0;
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (cycles % 5000 < 2000) field_stall <= 1'b0;
    else field_stall <= ($urandom_range(0, 99) < 40);
  end

  always @(posedge clk) begin
    field_word_t e;
    cycles <= cycles + 1;
    if (!rst && field_valid && !field_stall) begin
      fields_seen++;
      if (last_field) frames_seen++;
      if (expected_fields.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected field word idx=%0d", field_index);
      end else begin
        e = expected_fields.pop_front();
        if (e.idx !== field_index || e.val !== field_value || e.lng !== long_frame
            || e.lst !== last_field) begin
          mismatches++;
          if (mismatches <= 10)
            $display("field mismatch: exp idx=%0d val=%h long=%b last=%b, got %0d %h %b %b",
                     e.idx, e.val, e.lng, e.lst, field_index, field_value,
                     long_frame, last_field);
        end
      end
    end
  end

  initial begin
    cycles = 0;
    mismatches = 0;
    fields_seen = 0;
    frames_seen = 0;
    rx_fill = 0;
    sats = '0;
    diff_pos = '0;
    diff_head = '0;
    // few bytes, noise and a broken header ahead of the frame table
    byte_stream.push_back(8'h00);
    byte_stream.push_back(8'hFF);
    byte_stream.push_back(8'h12);
    byte_stream.push_back(SYNC_0);
    byte_stream.push_back(8'h00);
    byte_stream.push_back(8'h0B);
    for (int r = 0; r < 4; r++)
      queue_frame(int'(DIRECTED_ROWS[r].len), DIRECTED_ROWS[r].fill,
                  DIRECTED_ROWS[r].poll, DIRECTED_ROWS[r].corrupt);
    // random: mostly good frames, some broken, some noise
    while (byte_stream.size() < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 6)) byte_stream.push_back(8'($urandom));
        end
        1: begin
          queue_frame($urandom_range(0, 1) ? LONG_LEN : SHORT_LEN, FILL_RANDOM, 0, 1);
        end
        2: begin
          byte_stream.push_back(SYNC_0);
          byte_stream.push_back(SYNC_1);
        end
        default: begin
          queue_frame($urandom_range(0, 1) ? LONG_LEN : SHORT_LEN, FILL_RANDOM,
                      $urandom_range(0, 2) == 0, 0);
        end
      endcase
    end
    wait (!rst);
    while ((byte_stream.size() > 0 || byte_valid || expected_fields.size() > 0)
           && cycles < CYCLE_LIMIT) @(posedge clk);
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout with %0d field words outstanding", expected_fields.size());
      $display("[ins_frame_sync_xor_decoder_unit] ERROR");
      $finish;
    end else begin
      repeat (2000) @(posedge clk);
      $display("checked %0d field words from %0d frames, %0d mismatches",
               fields_seen, frames_seen, mismatches);
      if (mismatches == 0 && expected_fields.size() == 0)
        $display("[ins_frame_sync_xor_decoder_unit] OK");
      else
        $display("[ins_frame_sync_xor_decoder_unit] ERROR");
      $finish;
    end
  end
endmodule
